// ===== rtl/wrct_pkg.sv =====
// Shared types and constants for the written range coverage tracker.
package wrct_pkg;

   localparam int MAX_RANGES_DEFAULT = 64;
   localparam int OFFSET_W = 48;
   localparam int LENGTH_W = 32;
   localparam int END_W    = 49;
   localparam int COUNT_OUT_W = 7;

   // Command codes carried in the request tuser.
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // One stored range, start inclusive, end exclusive.
   typedef struct packed {
      logic [END_W-1:0]    range_end;
      logic [OFFSET_W-1:0] range_start;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_CK,
      ST_DECIDE,
      ST_COPY_RD,
      ST_COPY_WR,
      ST_WRITE_LO,
      ST_RESP
   } state_type;

endpackage

// ===== rtl/written_range_coverage_tracker.sv =====
// Top level of the written range coverage tracker.
//
// The block keeps a sorted table of disjoint, non-touching byte ranges in one
// synchronous memory with a registered read. A write request is merged with every
// stored range that overlaps or touches it; a query request reports whether its
// span lies inside one stored range. The block handles one request at a time.
// A linear scan reads each stored entry it visits from memory and then compares
// it, ends on the first entry past the request or at the end of the table, and
// is followed by a decide step. A write that merges or inserts then moves the
// tail of the table entry by entry, each a memory read then a write, and ends
// with the final write of the merged or new range. A zero-length write skips all
// of this, and a new range that finds the table full is dropped. The result
// register is loaded last; after that the block returns to idle, ready for the
// next request. A finished result waits only while the output register still
// holds an older one.
module written_range_coverage_tracker #(
   parameter int MAX_RANGES = wrct_pkg::MAX_RANGES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,   // offset [47:0], length [79:48]
   input  logic        req_tuser,   // command [0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // covered [0], dropped [1], range_count [8:2], zero [15:9]
);

   localparam int IW = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
   localparam int CW = $clog2(MAX_RANGES + 1);

   // Range table memory.
   wrct_pkg::entry_type mem [MAX_RANGES];
   wrct_pkg::entry_type rdata_ff;
   logic [IW-1:0]       raddr;
   logic                we;
   logic [IW-1:0]       waddr;
   wrct_pkg::entry_type wdata;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   // Control and working registers.
   wrct_pkg::state_type state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] newcnt_ff, newcnt_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] lo_ff, lo_in;
   logic [CW-1:0] src_ff, src_in;
   logic [CW-1:0] dst_ff, dst_in;
   logic          cmd_ff, cmd_in;
   logic          have_lo_ff, have_lo_in;
   logic          merged_ff, merged_in;
   logic          up_ff, up_in;
   logic [wrct_pkg::OFFSET_W-1:0] s_ff, s_in;
   logic [wrct_pkg::END_W-1:0]    e_ff, e_in;
   logic [wrct_pkg::OFFSET_W-1:0] ns_ff, ns_in;
   logic [wrct_pkg::END_W-1:0]    ne_ff, ne_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          covered_ff, covered_in;
   logic          dropped_ff, dropped_in;
   logic [wrct_pkg::COUNT_OUT_W-1:0] count_ff, count_in;
   logic          res_cov_ff, res_cov_in;
   logic          res_drop_ff, res_drop_in;

   logic [wrct_pkg::END_W-1:0] req_end;
   logic [wrct_pkg::END_W-1:0] ent_start_x;

   assign req_end = {1'b0, req_tdata[47:0]} +
                    {{(wrct_pkg::END_W - wrct_pkg::LENGTH_W){1'b0}}, req_tdata[79:48]};
   assign ent_start_x = {1'b0, rdata_ff.range_start};

   assign req_tready = (state_ff == wrct_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, count_ff, dropped_ff, covered_ff};

   // Next state and datapath control.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      newcnt_in    = newcnt_ff;
      idx_in       = idx_ff;
      lo_in        = lo_ff;
      src_in       = src_ff;
      dst_in       = dst_ff;
      cmd_in       = cmd_ff;
      have_lo_in   = have_lo_ff;
      merged_in    = merged_ff;
      up_in        = up_ff;
      s_in         = s_ff;
      e_in         = e_ff;
      ns_in        = ns_ff;
      ne_in        = ne_ff;
      rsp_valid_in = rsp_valid_ff;
      covered_in   = covered_ff;
      dropped_in   = dropped_ff;
      count_in     = count_ff;
      res_cov_in   = res_cov_ff;
      res_drop_in  = res_drop_ff;
      raddr        = idx_ff[IW-1:0];
      we           = 1'b0;
      waddr        = dst_ff[IW-1:0];
      wdata        = rdata_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         wrct_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in      = req_tuser;
               s_in        = req_tdata[47:0];
               e_in        = req_end;
               idx_in      = '0;
               have_lo_in  = 1'b0;
               merged_in   = 1'b0;
               res_cov_in  = 1'b0;
               res_drop_in = 1'b0;
               if (req_tuser == wrct_pkg::CMD_WRITE && req_tdata[79:48] == '0) begin
                  state_in = wrct_pkg::ST_RESP;
               end else begin
                  state_in = wrct_pkg::ST_SCAN_RD;
               end
            end
         end

         wrct_pkg::ST_SCAN_RD: begin
            if (idx_ff == cnt_ff) begin
               state_in = wrct_pkg::ST_DECIDE;
            end else begin
               state_in = wrct_pkg::ST_SCAN_CK;
            end
         end

         wrct_pkg::ST_SCAN_CK: begin
            state_in = wrct_pkg::ST_DECIDE;
            if (cmd_ff == wrct_pkg::CMD_QUERY) begin
               // Track the last range that starts at or below the query.
               if (rdata_ff.range_start <= s_ff) begin
                  have_lo_in = 1'b1;
                  ne_in      = rdata_ff.range_end;
                  idx_in     = idx_ff + 1'b1;
                  state_in   = wrct_pkg::ST_SCAN_RD;
               end
            end else if (!have_lo_ff) begin
               if (rdata_ff.range_end < {1'b0, s_ff}) begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = wrct_pkg::ST_SCAN_RD;
               end else begin
                  have_lo_in = 1'b1;
                  lo_in      = idx_ff;
                  if (ent_start_x <= e_ff) begin
                     merged_in = 1'b1;
                     ns_in = (rdata_ff.range_start < s_ff) ? rdata_ff.range_start : s_ff;
                     ne_in = (rdata_ff.range_end > e_ff) ? rdata_ff.range_end : e_ff;
                     idx_in   = idx_ff + 1'b1;
                     state_in = wrct_pkg::ST_SCAN_RD;
                  end
               end
            end else if (ent_start_x <= e_ff) begin
               // Further ranges absorbed by the write; ends rise along the table.
               ne_in    = (rdata_ff.range_end > ne_ff) ? rdata_ff.range_end : ne_ff;
               idx_in   = idx_ff + 1'b1;
               state_in = wrct_pkg::ST_SCAN_RD;
            end
         end

         wrct_pkg::ST_DECIDE: begin
            if (cmd_ff == wrct_pkg::CMD_QUERY) begin
               res_cov_in = have_lo_ff && (e_ff <= ne_ff);
               state_in   = wrct_pkg::ST_RESP;
            end else if (merged_ff) begin
               // Close the gap left by absorbed ranges.
               up_in     = 1'b0;
               dst_in    = lo_ff + 1'b1;
               src_in    = idx_ff;
               newcnt_in = cnt_ff - idx_ff + lo_ff + 1'b1;
               state_in  = wrct_pkg::ST_COPY_RD;
            end else if (cnt_ff >= CW'(MAX_RANGES)) begin
               res_drop_in = 1'b1;
               state_in    = wrct_pkg::ST_RESP;
            end else begin
               // Open a slot for the new range.
               if (!have_lo_ff) begin
                  lo_in = cnt_ff;
               end
               up_in     = 1'b1;
               dst_in    = cnt_ff;
               ns_in     = s_ff;
               ne_in     = e_ff;
               newcnt_in = cnt_ff + 1'b1;
               state_in  = wrct_pkg::ST_COPY_RD;
            end
         end

         wrct_pkg::ST_COPY_RD: begin
            if (up_ff) begin
               raddr = IW'(dst_ff - 1'b1);
               state_in = (dst_ff > lo_ff) ? wrct_pkg::ST_COPY_WR : wrct_pkg::ST_WRITE_LO;
            end else begin
               raddr = src_ff[IW-1:0];
               state_in = (src_ff < cnt_ff) ? wrct_pkg::ST_COPY_WR : wrct_pkg::ST_WRITE_LO;
            end
         end

         wrct_pkg::ST_COPY_WR: begin
            we = 1'b1;
            if (up_ff) begin
               dst_in = dst_ff - 1'b1;
            end else begin
               dst_in = dst_ff + 1'b1;
               src_in = src_ff + 1'b1;
            end
            state_in = wrct_pkg::ST_COPY_RD;
         end

         wrct_pkg::ST_WRITE_LO: begin
            we                = 1'b1;
            waddr             = lo_ff[IW-1:0];
            wdata.range_start = ns_ff;
            wdata.range_end   = ne_ff;
            cnt_in            = newcnt_ff;
            state_in          = wrct_pkg::ST_RESP;
         end

         wrct_pkg::ST_RESP: begin
            // The count is captured with the result so it holds while the result waits.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               covered_in   = res_cov_ff;
               dropped_in   = res_drop_ff;
               count_in     = wrct_pkg::COUNT_OUT_W'(cnt_ff);
               state_in     = wrct_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = wrct_pkg::ST_IDLE;
         end
      endcase
   end

   // State, count and valid registers are reset; payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wrct_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      newcnt_ff   <= newcnt_in;
      idx_ff      <= idx_in;
      lo_ff       <= lo_in;
      src_ff      <= src_in;
      dst_ff      <= dst_in;
      cmd_ff      <= cmd_in;
      have_lo_ff  <= have_lo_in;
      merged_ff   <= merged_in;
      up_ff       <= up_in;
      s_ff        <= s_in;
      e_ff        <= e_in;
      ns_ff       <= ns_in;
      ne_ff       <= ne_in;
      covered_ff  <= covered_in;
      dropped_ff  <= dropped_in;
      count_ff    <= count_in;
      res_cov_ff  <= res_cov_in;
      res_drop_ff <= res_drop_in;
   end

endmodule

// ===== bench/tb_written_range_coverage_tracker.sv =====
// Testbench for the written range coverage tracker: directed and random requests checked against a local predictor.
module tb_written_range_coverage_tracker;

   localparam int TABLE_DEPTH = wrct_pkg::MAX_RANGES_DEFAULT;
   localparam int STALL_LIMIT = 5000;
   localparam int TAIL_CYCLES = 4 * TABLE_DEPTH + 20;

   typedef struct {
      logic       covered;
      logic       dropped;
      logic [6:0] range_count;
   } outcome_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [79:0] req_tdata;   // offset [47:0], length [79:48]
   logic        req_tuser;   // command [0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // covered [0], dropped [1], range_count [8:2], zero [15:9]

   // Predicted copy of the range table.
   logic [wrct_pkg::OFFSET_W-1:0] model_start [TABLE_DEPTH];
   logic [wrct_pkg::END_W-1:0]    model_end   [TABLE_DEPTH];
   int unsigned                   model_count;

   outcome_type pending_outcomes[$];
   int          mismatch_count;
   bit          steady_mode;
   int          quiet_cycles;

   written_range_coverage_tracker u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Merge a written range into the predicted table, as the block should.
   function automatic logic record_range(logic [wrct_pkg::OFFSET_W-1:0] s,
                                         logic [wrct_pkg::END_W-1:0] e);
      int unsigned lo, hi, gone;
      lo = 0;
      while (lo < model_count && model_end[lo] < {1'b0, s}) lo++;
      hi = lo;
      while (hi < model_count && {1'b0, model_start[hi]} <= e) hi++;
      if (hi > lo) begin
         if (model_start[lo] > s) model_start[lo] = s;
         model_end[lo] = (model_end[hi-1] > e) ? model_end[hi-1] : e;
         gone = hi - lo - 1;
         for (int unsigned i = lo + 1; i + gone < model_count; i++) begin
            model_start[i] = model_start[i+gone];
            model_end[i]   = model_end[i+gone];
         end
         model_count -= gone;
         return 1'b0;
      end
      if (model_count >= TABLE_DEPTH) return 1'b1;
      for (int unsigned i = model_count; i > lo; i--) begin
         model_start[i] = model_start[i-1];
         model_end[i]   = model_end[i-1];
      end
      model_start[lo] = s;
      model_end[lo]   = e;
      model_count++;
      return 1'b0;
   endfunction

   // Coverage check of a span against the predicted table.
   function automatic logic span_covered(logic [wrct_pkg::OFFSET_W-1:0] s,
                                         logic [wrct_pkg::END_W-1:0] e);
      int unsigned i;
      i = 0;
      while (i < model_count && model_start[i] <= s) i++;
      if (i == 0) return 1'b0;
      return (e <= model_end[i-1]);
   endfunction

   function automatic outcome_type predict_outcome(logic cmd,
                                                   logic [wrct_pkg::OFFSET_W-1:0] off,
                                                   logic [wrct_pkg::LENGTH_W-1:0] len);
      outcome_type o;
      logic [wrct_pkg::END_W-1:0] e;
      e = {1'b0, off} + {17'd0, len};
      o.covered = 1'b0;
      o.dropped = 1'b0;
      if (cmd == wrct_pkg::CMD_WRITE) begin
         if (len != 0) o.dropped = record_range(off, e);
      end else begin
         o.covered = span_covered(off, e);
      end
      o.range_count = model_count[6:0];
      return o;
   endfunction

   // Send one request, with a random gap first unless in a steady stretch.
   task automatic send_request(logic cmd, logic [wrct_pkg::OFFSET_W-1:0] off,
                               logic [wrct_pkg::LENGTH_W-1:0] len);
      int gap;
      @(negedge clock);
      gap = (!steady_mode && $urandom_range(99) < 30) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {len, off};
      do @(posedge clock); while (!req_tready);
      pending_outcomes.push_back(predict_outcome(cmd, off, len));
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_outcomes.size() != 0) @(negedge clock);
   endtask

   // Extremes of the fields and each special case.
   task automatic test_directed();
      send_request(wrct_pkg::CMD_QUERY, 48'd100, 32'd10);       // empty table
      send_request(wrct_pkg::CMD_QUERY, 48'd0, 32'd0);          // zero-length, empty
      send_request(wrct_pkg::CMD_WRITE, 48'd500, 32'd0);        // zero-length write
      send_request(wrct_pkg::CMD_WRITE, 48'd100, 32'd100);      // [100,200)
      send_request(wrct_pkg::CMD_WRITE, 48'd200, 32'd50);       // touches: [100,250)
      send_request(wrct_pkg::CMD_WRITE, 48'd251, 32'd9);        // one-byte gap stays apart
      send_request(wrct_pkg::CMD_QUERY, 48'd100, 32'd150);
      send_request(wrct_pkg::CMD_QUERY, 48'd100, 32'd151);      // crosses gap
      send_request(wrct_pkg::CMD_QUERY, 48'd250, 32'd0);        // end point counts
      send_request(wrct_pkg::CMD_QUERY, 48'd50, 32'd10);        // before first range
      send_request(wrct_pkg::CMD_WRITE, 48'd400, 32'd20);
      send_request(wrct_pkg::CMD_WRITE, 48'd90, 32'd400);       // swallows several
      send_request(wrct_pkg::CMD_QUERY, 48'd90, 32'd400);
      send_request(wrct_pkg::CMD_WRITE, 48'd0, 32'hFFFF_FFFF);
      send_request(wrct_pkg::CMD_WRITE, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF); // end beyond 48 bits
      send_request(wrct_pkg::CMD_QUERY, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF);
      send_request(wrct_pkg::CMD_QUERY, 48'hFFFF_FFFF_FFFF, 32'd0);
      send_request(wrct_pkg::CMD_QUERY, 48'd0, 32'hFFFF_FFFF);
      send_request(wrct_pkg::CMD_QUERY, 48'hFFFF_0000_0000, 32'd1);
   endtask

   // Fill the table, then try a new range and a merging range while full, then new ranges after the merge.
   task automatic test_table_full();
      for (int i = 0; i < TABLE_DEPTH + 2; i++)
         send_request(wrct_pkg::CMD_WRITE, 48'h0001_0000_0000 + 48'(i * 64), 32'd16);
      send_request(wrct_pkg::CMD_WRITE, 48'h0002_0000_0000, 32'd5);  // dropped
      send_request(wrct_pkg::CMD_WRITE, 48'h0001_0000_0010, 32'd48); // merges two while full
      send_request(wrct_pkg::CMD_WRITE, 48'h0002_0000_0000, 32'd5);  // now fits
      send_request(wrct_pkg::CMD_WRITE, 48'h0003_0000_0000, 32'd5);  // dropped again
   endtask

   // Random requests in a small window so writes merge and queries hit.
   task automatic test_random(int count);
      logic [wrct_pkg::OFFSET_W-1:0] base, off;
      logic [wrct_pkg::LENGTH_W-1:0] len;
      logic cmd;
      base = wrct_pkg::OFFSET_W'({$urandom, $urandom});
      for (int n = 0; n < count; n++) begin
         if (n % 200 == 0) base = wrct_pkg::OFFSET_W'({$urandom, $urandom});
         cmd = ($urandom_range(99) < 45) ? wrct_pkg::CMD_QUERY : wrct_pkg::CMD_WRITE;
         if ($urandom_range(99) < 8) begin
            off = wrct_pkg::OFFSET_W'({$urandom, $urandom});
            len = $urandom;
         end else begin
            off = base + 48'($urandom_range(0, 3000));
            len = ($urandom_range(9) == 0) ? 32'd0 : 32'($urandom_range(1, 120));
         end
         send_request(cmd, off, len);
      end
   endtask

   // Receiver back-pressure.
   always @(negedge clock)
      rsp_tready <= steady_mode || ($urandom_range(99) >= 30);

   // Compare each result with the oldest prediction.
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_outcomes.size() == 0) begin
            $error("unexpected result, tdata %h", rsp_tdata);
            mismatch_count++;
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_tdata[0] !== want.covered) begin
               $error("covered: expected %0d, actual %0d", want.covered, rsp_tdata[0]);
               mismatch_count++;
            end
            if (rsp_tdata[1] !== want.dropped) begin
               $error("dropped: expected %0d, actual %0d", want.dropped, rsp_tdata[1]);
               mismatch_count++;
            end
            if (rsp_tdata[8:2] !== want.range_count) begin
               $error("range_count: expected %0d, actual %0d",
                      want.range_count, rsp_tdata[8:2]);
               mismatch_count++;
            end
         end
      end
   end

   // Watchdog on cycles with no handshake on either side.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = wrct_pkg::CMD_WRITE;
      rsp_tready     = 1'b0;
      steady_mode    = 1'b0;
      mismatch_count = 0;
      quiet_cycles   = 0;
      model_count    = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_table_full();
      test_random(350);
      wait_for_drain();
      steady_mode = 1'b1;
      test_random(150);
      steady_mode = 1'b0;
      test_random(300);
      wait_for_drain();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_outcomes.size() != 0) begin
         $error("%0d results never arrived", pending_outcomes.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/wrct_pkg.sv
rtl/written_range_coverage_tracker.sv
bench/tb_written_range_coverage_tracker.sv
